// ----- hw/rtl/ufbs_pkg.sv -----
// ============================================================================
// ufbs_pkg - shared types and constants for the union-find-by-size block
// Sequencer states, request and status codes, register reset value.
// ============================================================================
package ufbs_pkg;

    // request kinds carried in the input tuser bit
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_UNITE = 1'b1;

    // result status carried in the output tuser bit
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_RANGE_ERR = 1'b1;

    // element-count register value after reset (clamped to table depth)
    localparam int unsigned CFG_NUM_RESET = 1024;

    typedef enum logic [2:0] {
        S_CLEAR,    // clearing pass over both stores after reset
        S_IDLE,     // waiting for a request beat
        S_WALK_A,   // following parent links from elem_a
        S_WALK_B,   // following parent links from elem_b
        S_SZ_A,     // size of root a arrives
        S_SZ_B,     // size of root b arrives, link written back
        S_OUT       // result waits for the output register
    } t_state;

endpackage

// ----- hw/rtl/ufbs_ram.sv -----
// ============================================================================
// ufbs_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module ufbs_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/union_find_by_size_top.sv -----
// ============================================================================
// union_find_by_size_top - disjoint-set table, union by size
// Walks parent links in a RAM to each element's root, answers same-set
// queries and joins sets, smaller root under larger root.
// ============================================================================
//
// Channel   Dir  Signals                          Content
// --------  ---  -------------------------------  -----------------------------
// request   in   s_axis_tvalid/tready/tdata/tuser  tdata: elem_a, elem_b
//                                                  tuser: req_type
// result    out  m_axis_tvalid/tready/tdata/tuser  tdata: were_connected, merged,
//                                                  result_root, root_set_size
//                                                  tuser: status
// config    in   i_cfg_we, i_cfg_wdata             num_elements
//
// A request takes (depth_a + 1) + (depth_b + 1) parent reads, then one or
//   two size reads; the result then passes from S_OUT into the output
//   register and the sequencer goes back to idle. Union by size keeps
//   tree depth at or under log2(MAX_ELEMENTS). The single read port of
//   the parent RAM limits the walk to one link step per cycle.
// Range errors skip the walk and go straight from idle to S_OUT.
// Reset: a clearing pass writes parent = 0 and size = 1 to every entry;
//   s_axis_tready stays low until it completes.
//   Config writes are taken during the pass.
// Stalls: the result sits in an output register; a new request is accepted
//   while it waits, and the sequencer holds in S_OUT only if the next result
//   is ready before the previous one is taken.
// ============================================================================
module union_find_by_size_top
    import ufbs_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration: num_elements
    input  logic                                 i_cfg_we,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0]    i_cfg_wdata,
    // request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, low bit up: elem_a, elem_b, zero pad
    input  logic [((2*$clog2(MAX_ELEMENTS+1)+7)/8)*8-1:0] s_axis_tdata,
    // tuser: req_type
    input  logic                                 s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata, low bit up: were_connected, merged, result_root, root_set_size, pad
    output logic [((2+2*$clog2(MAX_ELEMENTS+1)+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status
    output logic                                 m_axis_tuser
);

    // element number width (holds MAX_ELEMENTS itself) and RAM index width
    localparam int unsigned EW     = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned AW     = $clog2(MAX_ELEMENTS);
    localparam int unsigned NUM_RST =
        (MAX_ELEMENTS < CFG_NUM_RESET) ? MAX_ELEMENTS : CFG_NUM_RESET;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_idx;
    logic [EW-1:0]   r_num;

    logic [EW-1:0]   r_cur,   n_cur;      // element under the walk
    logic [EW-1:0]   r_elem_b, n_elem_b;
    logic            r_unite, n_unite;
    logic [EW-1:0]   r_ra,    n_ra;
    logic [EW-1:0]   r_rb,    n_rb;
    logic            r_conn,  n_conn;
    logic [EW-1:0]   r_sa,    n_sa;

    // finished result, waiting for the output register
    logic            r_res_status, n_res_status;
    logic            r_res_merged, n_res_merged;
    logic [EW-1:0]   r_res_root,   n_res_root;
    logic [EW-1:0]   r_res_size,   n_res_size;

    // output register
    logic            r_out_valid;
    logic            r_out_status;
    logic            r_out_conn;
    logic            r_out_merged;
    logic [EW-1:0]   r_out_root;
    logic [EW-1:0]   r_out_size;

    // ------------------------------------------------------------------
    // RAM ports
    // ------------------------------------------------------------------
    logic            par_we;
    logic [AW-1:0]   par_waddr;
    logic [EW-1:0]   par_wdata;
    logic [AW-1:0]   par_raddr;
    logic [EW-1:0]   par_rdata;

    logic            sz_we;
    logic [AW-1:0]   sz_waddr;
    logic [EW-1:0]   sz_wdata;
    logic [AW-1:0]   sz_raddr;
    logic [EW-1:0]   sz_rdata;

    ufbs_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMENTS)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    ufbs_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMENTS)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (sz_we),
        .i_waddr (sz_waddr),
        .i_wdata (sz_wdata),
        .i_raddr (sz_raddr),
        .o_rdata (sz_rdata)
    );

    // ------------------------------------------------------------------
    // request decode and range check
    // ------------------------------------------------------------------
    logic [EW-1:0]   in_a, in_b;
    logic [EW-1:0]   num_eff;
    logic            in_ok;
    logic            accept;
    logic            out_free;
    logic            clr_last;
    logic            merge_go;

    assign in_a     = s_axis_tdata[0 +: EW];
    assign in_b     = s_axis_tdata[EW +: EW];
    // register values above the table depth act as the depth
    assign num_eff  = (r_num > EW'(MAX_ELEMENTS)) ? EW'(MAX_ELEMENTS) : r_num;
    assign in_ok    = (in_a != '0) && (in_a <= num_eff) &&
                      (in_b != '0) && (in_b <= num_eff);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign clr_last = (r_clr_idx == AW'(MAX_ELEMENTS - 1));
    assign merge_go = (r_unite == REQ_UNITE) && !r_conn;

    assign s_axis_tready = (r_state == S_IDLE);

    // one-based element number to RAM index
    function automatic logic [AW-1:0] to_addr(input logic [EW-1:0] e);
        logic [EW-1:0] em1;
        em1 = e - EW'(1);
        return em1[AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = in_ok ? S_WALK_A : S_OUT;
            end
            S_WALK_A: begin
                if (par_rdata == '0) n_state = S_WALK_B;
            end
            S_WALK_B: begin
                if (par_rdata == '0) n_state = S_SZ_A;
            end
            S_SZ_A: begin
                n_state = merge_go ? S_SZ_B : S_OUT;
            end
            S_SZ_B: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // RAM control and datapath
    // ------------------------------------------------------------------
    always_comb begin
        logic [EW:0] sum_w;
        logic [EW-1:0] sum;

        sum_w = {1'b0, r_sa} + {1'b0, sz_rdata};
        sum   = sum_w[EW-1:0];   // set sizes never exceed MAX_ELEMENTS

        par_we    = 1'b0;
        par_waddr = r_clr_idx;
        par_wdata = '0;
        par_raddr = to_addr(r_cur);
        sz_we     = 1'b0;
        sz_waddr  = r_clr_idx;
        sz_wdata  = EW'(1);
        sz_raddr  = to_addr(r_ra);

        n_cur        = r_cur;
        n_elem_b     = r_elem_b;
        n_unite      = r_unite;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_conn       = r_conn;
        n_sa         = r_sa;
        n_res_status = r_res_status;
        n_res_merged = r_res_merged;
        n_res_root   = r_res_root;
        n_res_size   = r_res_size;

        unique case (r_state)
            S_CLEAR: begin
                par_we = 1'b1;
                sz_we  = 1'b1;
            end
            S_IDLE: begin
                par_raddr = to_addr(in_a);
                if (accept) begin
                    n_cur    = in_a;
                    n_elem_b = in_b;
                    n_unite  = s_axis_tuser;
                    if (!in_ok) begin
                        n_res_status = ST_RANGE_ERR;
                        n_res_merged = 1'b0;
                        n_res_root   = '0;
                        n_res_size   = '0;
                        n_conn       = 1'b0;
                    end
                end
            end
            S_WALK_A: begin
                if (par_rdata == '0) begin
                    n_ra      = r_cur;
                    n_cur     = r_elem_b;
                    par_raddr = to_addr(r_elem_b);
                end else begin
                    n_cur     = par_rdata;
                    par_raddr = to_addr(par_rdata);
                end
            end
            S_WALK_B: begin
                if (par_rdata == '0) begin
                    n_rb   = r_cur;
                    n_conn = (r_cur == r_ra);
                end else begin
                    n_cur     = par_rdata;
                    par_raddr = to_addr(par_rdata);
                end
            end
            S_SZ_A: begin
                n_sa     = sz_rdata;
                sz_raddr = to_addr(r_rb);
                if (!merge_go) begin
                    n_res_status = ST_OK;
                    n_res_merged = 1'b0;
                    n_res_root   = r_ra;
                    n_res_size   = sz_rdata;
                end
            end
            S_SZ_B: begin
                par_we = 1'b1;
                sz_we  = 1'b1;
                sz_wdata = sum;
                if (r_sa < sz_rdata) begin
                    // a is strictly smaller: hang root a under root b
                    par_waddr  = to_addr(r_ra);
                    par_wdata  = r_rb;
                    sz_waddr   = to_addr(r_rb);
                    n_res_root = r_rb;
                end else begin
                    // ties go to the first element's root
                    par_waddr  = to_addr(r_rb);
                    par_wdata  = r_ra;
                    sz_waddr   = to_addr(r_ra);
                    n_res_root = r_ra;
                end
                n_res_status = ST_OK;
                n_res_merged = 1'b1;
                n_res_size   = sum;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_num       <= EW'(NUM_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_elem_b     <= n_elem_b;
        r_unite      <= n_unite;
        r_ra         <= n_ra;
        r_rb         <= n_rb;
        r_conn       <= n_conn;
        r_sa         <= n_sa;
        r_res_status <= n_res_status;
        r_res_merged <= n_res_merged;
        r_res_root   <= n_res_root;
        r_res_size   <= n_res_size;
        if (r_state == S_OUT && out_free) begin
            r_out_status <= r_res_status;
            r_out_conn   <= r_conn;
            r_out_merged <= r_res_merged;
            r_out_root   <= r_res_root;
            r_out_size   <= r_res_size;
        end
    end

    // ------------------------------------------------------------------
    // result beat
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;

    always_comb begin
        m_axis_tdata            = '0;
        m_axis_tdata[0]         = r_out_conn;
        m_axis_tdata[1]         = r_out_merged;
        m_axis_tdata[2 +: EW]   = r_out_root;
        m_axis_tdata[2+EW +: EW] = r_out_size;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after a request beat");

    a_link_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SZ_B) |-> (par_we && sz_we && (par_waddr != sz_waddr)))
        else $error("merge wrote link and size to the same root");

    a_merge_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_merged) |-> (!r_out_conn && (r_out_root != '0)))
        else $error("merged result claims sets were already connected");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_OK)) |-> (r_out_size != '0))
        else $error("good result with zero set size");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_RANGE_ERR)) |->
            (!r_out_conn && !r_out_merged && (r_out_root == '0)))
        else $error("range error result carries data");

endmodule

// ----- tb/sv/ufbs_tb_pkg.sv -----
// ============================================================================
// ufbs_tb_pkg - disjoint-set predictor and result scoreboard
// Keeps its own parent and size tables, works out the answer for every
// accepted request and checks each returned beat against the oldest answer.
// ============================================================================
package ufbs_tb_pkg;
    import ufbs_pkg::*;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned EW          = 11;

    typedef struct packed {
        logic          status;
        logic          were_connected;
        logic          merged;
        logic [EW-1:0] root;
        logic [EW-1:0] root_size;
    } t_dsu_answer;

    class dsu_scoreboard;
        int unsigned up_link [TABLE_DEPTH];   // 0 = root, else parent element
        int unsigned members [TABLE_DEPTH];   // set size, valid at roots
        int unsigned elem_count;
        t_dsu_answer answers [$];
        int unsigned mismatches;
        int unsigned n_checked;
        int unsigned n_unites;
        int unsigned n_merges;
        int unsigned n_range_errs;

        function new();
            elem_count = CFG_NUM_RESET;
            foreach (up_link[i]) begin
                up_link[i] = 0;
                members[i] = 1;
            end
            mismatches   = 0;
            n_checked    = 0;
            n_unites     = 0;
            n_merges     = 0;
            n_range_errs = 0;
        endfunction

        function void set_count(logic [EW-1:0] value);
            elem_count = 32'(value);
        endfunction

        function int unsigned usable();
            return (elem_count > TABLE_DEPTH) ? TABLE_DEPTH : elem_count;
        endfunction

        // no path compression; bounded walk
        function int unsigned root_of(int unsigned e);
            for (int unsigned k = 0; k < TABLE_DEPTH; k++) begin
                if (e < 1 || e > TABLE_DEPTH)
                    break;
                if (up_link[e-1] == 0 || up_link[e-1] > TABLE_DEPTH)
                    break;
                e = up_link[e-1];
            end
            return e;
        endfunction

        function void note_request(logic kind, logic [EW-1:0] a, logic [EW-1:0] b);
            int unsigned n;
            int unsigned ra;
            int unsigned rb;
            int unsigned sz_a;
            int unsigned sz_b;
            int unsigned top;
            t_dsu_answer ans;
            n   = usable();
            ans = '0;
            if (kind == REQ_UNITE)
                n_unites++;
            if (a < 1 || a > n || b < 1 || b > n) begin
                ans.status = ST_RANGE_ERR;
                n_range_errs++;
                answers.push_back(ans);
                return;
            end
            ra  = root_of(32'(a));
            rb  = root_of(32'(b));
            top = ra;
            ans.status         = ST_OK;
            ans.were_connected = (ra == rb);
            if (kind == REQ_UNITE && ra != rb) begin
                sz_a = members[ra-1];
                sz_b = members[rb-1];
                if (sz_a < sz_b) begin
                    up_link[ra-1] = rb;
                    members[rb-1] = (sz_a + sz_b) & 32'h1FFFF;
                    top = rb;
                end else begin
                    up_link[rb-1] = ra;
                    members[ra-1] = (sz_a + sz_b) & 32'h1FFFF;
                end
                ans.merged = 1'b1;
                n_merges++;
            end
            ans.root      = top[EW-1:0];
            ans.root_size = members[top-1][EW-1:0];
            answers.push_back(ans);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH: %s", $time, what);
        endfunction

        function void check_result(t_dsu_answer got);
            t_dsu_answer want;
            if (answers.size() == 0) begin
                flag($sformatf("result beat with nothing outstanding: %p", got));
                return;
            end
            want = answers.pop_front();
            n_checked++;
            if (got.status !== want.status || got.were_connected !== want.were_connected ||
                got.merged !== want.merged || got.root !== want.root ||
                got.root_size !== want.root_size)
                flag($sformatf({"result %0d exp st=%0b conn=%0b mrg=%0b root=%0d size=%0d",
                                " got st=%0b conn=%0b mrg=%0b root=%0d size=%0d"},
                               n_checked, want.status, want.were_connected, want.merged,
                               want.root, want.root_size, got.status, got.were_connected,
                               got.merged, got.root, got.root_size));
        endfunction

        function void finish_check();
            if (answers.size() != 0)
                flag($sformatf("%0d results never returned", answers.size()));
        endfunction
    endclass

endpackage

// ----- tb/sv/union_find_by_size_top_tb.sv -----
// ============================================================================
// union_find_by_size_top_tb - testbench for the disjoint-set table
// Drives query and unite requests over the request stream, checks every
// result beat against a table-based predictor, and sweeps the element
// count through its extremes, including shrinking below existing links.
// ============================================================================
module union_find_by_size_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufbs_pkg::*;
    import ufbs_tb_pkg::*;

    // cycles with no beat on either stream before the run is called hung;
    // the clearing pass after reset also counts as quiet
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned N_PHASES    = 12;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_we      = 1'b0;
    logic [EW-1:0] i_cfg_wdata   = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [23:0]   s_axis_tdata  = '0;   // elem_a [10:0], elem_b [21:11], pad
    logic          s_axis_tuser  = 1'b0; // req_type
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [23:0]   m_axis_tdata;         // were_connected, merged, root, size
    logic          m_axis_tuser;         // status

    dsu_scoreboard board = new();

    bit          idle_on    = 1'b0;      // random gaps on both streams
    int unsigned stall_left = 0;
    int unsigned quiet      = 0;
    int unsigned n_settings = 1;         // reset value counts as one

    // random part: element count, beats, unite percentage, idling
    int unsigned phase_count [N_PHASES] = '{32, 5, 1024, 128, 2047, 16, 300, 1, 64, 0, 1000, 24};
    int unsigned phase_items [N_PHASES] = '{120, 40, 150, 100, 60, 80, 100, 15, 100, 15, 80, 90};
    int unsigned phase_unite [N_PHASES] = '{50, 60, 45, 40, 50, 30, 55, 50, 35, 50, 45, 40};
    bit          phase_idle  [N_PHASES] = '{1, 1, 0, 1, 1, 0, 1, 1, 1, 0, 1, 0};

    union_find_by_size_top #(
        .MAX_ELEMENTS (TABLE_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitor: both streams sampled at the edge. The result check runs
    // before the request is noted so a stray result beat can never be
    // matched against a request accepted on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result({m_axis_tuser, m_axis_tdata[0], m_axis_tdata[1],
                                    m_axis_tdata[12:2], m_axis_tdata[23:13]});
            if (s_axis_tvalid && s_axis_tready)
                board.note_request(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[21:11]);
        end
    end

    // Result-side backpressure: tready drops in random-length bursts while idling
    // is on, otherwise always ready.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(16, 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: counts cycles with no beat on either stream.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("union_find_by_size_top verification failed");
            $finish;
        end
    end

    // One request beat. An optional gap goes in front of it; tvalid is left
    // high after the beat so back-to-back requests never drop it within
    // the edge where one beat ends and the next begins.
    task automatic send_request(logic kind, logic [EW-1:0] a, logic [EW-1:0] b);
        if (idle_on && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop tvalid and wait until every noted request has been answered.
    // The first edge lets the monitor note the last accepted beat.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.answers.size() > 0)
            @(posedge i_clk);
    endtask

    // Element-count write, only with the block idle.
    task automatic write_count(logic [EW-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_count(value);
        n_settings++;
    endtask

    // Mostly in-range pairs, so unites keep growing the trees; the rest is
    // noise over the whole 11-bit field, often only one element bad.
    task automatic random_burst(int unsigned items, int unsigned unite_pct);
        int unsigned   n;
        logic          kind;
        logic [EW-1:0] a;
        logic [EW-1:0] b;
        n = board.usable();
        repeat (items) begin
            kind = ($urandom_range(99) < unite_pct) ? REQ_UNITE : REQ_QUERY;
            if (n > 0 && $urandom_range(99) < 85) begin
                a = EW'($urandom_range(n, 1));
                b = EW'($urandom_range(n, 1));
            end else begin
                a = EW'($urandom_range(2047));
                if ($urandom_range(1) == 0 || n == 0)
                    b = EW'($urandom_range(2047));
                else
                    b = EW'($urandom_range(n, 1));
            end
            send_request(kind, a, b);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        // --- directed, at the reset element count ---
        send_request(REQ_QUERY, 11'd1, 11'd1);        // single-element set
        send_request(REQ_QUERY, 11'd1024, 11'd1024);  // top element
        send_request(REQ_UNITE, 11'd1, 11'd1024);     // equal sizes: b under a
        send_request(REQ_UNITE, 11'd1024, 11'd2);     // a walks, larger keeps root
        send_request(REQ_UNITE, 11'd3, 11'd1);        // smaller first root moves
        send_request(REQ_UNITE, 11'd3, 11'd2);        // already joined
        send_request(REQ_QUERY, 11'd3, 11'd1024);
        send_request(REQ_UNITE, 11'd1000, 11'd999);   // 999 under 1000
        send_request(REQ_QUERY, 11'd0, 11'd5);        // zero element
        send_request(REQ_UNITE, 11'd5, 11'd0);
        send_request(REQ_QUERY, 11'd1025, 11'd1);     // just past the count
        send_request(REQ_UNITE, 11'd2047, 11'd2047);  // all ones
        send_request(REQ_QUERY, 11'd682, 11'd1365);   // second one bad only
        send_request(REQ_UNITE, 11'd682, 11'd341);

        // zero count: everything is a range error
        write_count(11'd0);
        send_request(REQ_UNITE, 11'd1, 11'd1);
        send_request(REQ_QUERY, 11'd1024, 11'd1024);

        // one element
        write_count(11'd1);
        send_request(REQ_UNITE, 11'd1, 11'd1);
        send_request(REQ_QUERY, 11'd1, 11'd2);

        // above the table depth: clamps to it
        write_count(11'd2047);
        send_request(REQ_UNITE, 11'd1024, 11'd1000);
        send_request(REQ_QUERY, 11'd1025, 11'd1024);

        // shrunk count: walks still pass through 1000, one beyond it
        write_count(11'd999);
        send_request(REQ_QUERY, 11'd999, 11'd999);
        send_request(REQ_UNITE, 11'd999, 11'd5);

        // --- random phases; the last one runs with no gaps ---
        for (int p = 0; p < N_PHASES; p++) begin
            write_count(phase_count[p][EW-1:0]);
            idle_on = phase_idle[p];
            random_burst(phase_items[p], phase_unite[p]);
        end

        drain();
        repeat (40) @(posedge i_clk);
        board.finish_check();

        $display("checked %0d results: %0d unites, %0d merges, %0d range errors",
                 board.n_checked, board.n_unites, board.n_merges, board.n_range_errs);
        $display("element count written %0d times, %0d mismatches",
                 n_settings - 1, board.mismatches);
        if (board.mismatches == 0)
            $display("union_find_by_size_top verification clean");
        else
            $display("union_find_by_size_top verification failed");
        $finish;
    end

endmodule
